### sv/hdmi_acr_n_cts_calc_assert.svh
// Assertion macros shared by the ACR N/CTS calculator modules.
`ifndef HDMI_ACR_N_CTS_CALC_ASSERT_SVH
`define HDMI_ACR_N_CTS_CALC_ASSERT_SVH

// Concurrent assertion on the rising clock edge, held off while in reset.
`define HACR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: the consequent must hold in the same cycle as the antecedent.
`define HACR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/hacr_pkg.sv
package hacr_pkg;

  // Field widths.
  localparam int unsigned PclkW = 22;
  localparam int unsigned RateW = 18;
  localparam int unsigned NW    = 15;
  localparam int unsigned CtsW  = 32;

  // Every table N is a multiple of 128, so N/128 cancels the 128 in the divisor.
  localparam int unsigned NShift = 7;
  localparam int unsigned ScaleW = NW - NShift;

  // The pixel clock is scaled from kHz to Hz.
  localparam int unsigned PclkScale = 1000;
  localparam int unsigned PclkHzW   = 32;
  localparam int unsigned NumW      = PclkHzW + ScaleW;
  localparam int unsigned RemW      = RateW;

  // Divider organization: a fixed number of quotient bits per stage.
  localparam int unsigned DivBitsPerStage = 4;
  localparam int unsigned DivStages       = NumW / DivBitsPerStage;

  // Stream widths.
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned OutTuserW = 2;

  // Standard audio rates in Hz.
  localparam logic [RateW-1:0] Rate32k   = RateW'(32000);
  localparam logic [RateW-1:0] Rate44k1  = RateW'(44100);
  localparam logic [RateW-1:0] Rate48k   = RateW'(48000);
  localparam logic [RateW-1:0] Rate88k2  = RateW'(88200);
  localparam logic [RateW-1:0] Rate96k   = RateW'(96000);
  localparam logic [RateW-1:0] Rate176k4 = RateW'(176400);
  localparam logic [RateW-1:0] Rate192k  = RateW'(192000);

  // Matching N values.
  localparam logic [NW-1:0] N32k      = NW'(4096);
  localparam logic [NW-1:0] N44k1     = NW'(6272);
  localparam logic [NW-1:0] N48k      = NW'(6144);
  localparam logic [NW-1:0] N88k2     = NW'(12544);
  localparam logic [NW-1:0] N96k      = NW'(12288);
  localparam logic [NW-1:0] N176k4    = NW'(25088);
  localparam logic [NW-1:0] N192k     = NW'(24576);
  localparam logic [NW-1:0] NFallback = NW'(6144);

  // Payload carried through the divider stages.
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [NumW-1:0]  dq;       // dividend bits leave at the top, quotient bits enter below
    logic [RateW-1:0] divisor;
    logic [NW-1:0]    n;
    logic             err;
  } div_t;

  // Picks N from the standard table, with the fallback for any other rate.
  function automatic logic [NW-1:0] pick_n(input logic [RateW-1:0] rate);
    logic [NW-1:0] n;
    unique case (rate)
      Rate32k:   n = N32k;
      Rate44k1:  n = N44k1;
      Rate48k:   n = N48k;
      Rate88k2:  n = N88k2;
      Rate96k:   n = N96k;
      Rate176k4: n = N176k4;
      Rate192k:  n = N192k;
      default:   n = NFallback;
    endcase
    return n;
  endfunction

endpackage

### sv/hacr_prep.sv
`include "hdmi_acr_n_cts_calc_assert.svh"

module hacr_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [hacr_pkg::PclkW-1:0]  pclk_i,
  input  logic [hacr_pkg::RateW-1:0]  rate_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output hacr_pkg::div_t              stage_o
);
  import hacr_pkg::*;

  // Stage A: N lookup and pixel clock scaled to Hz.
  logic                 a_valid_d, a_valid_q;
  logic                 a_ready;
  logic [PclkHzW-1:0]   a_pclk_hz_d, a_pclk_hz_q;
  logic [RateW-1:0]     a_rate_q;
  logic [NW-1:0]        a_n_d, a_n_q;

  // Stage B: full numerator.
  logic                 b_valid_d, b_valid_q;
  logic                 b_ready;
  logic [NumW-1:0]      b_num_d, b_num_q;
  logic [RateW-1:0]     b_rate_q;
  logic [NW-1:0]        b_n_q;
  logic                 b_err_d, b_err_q;

  // A stage takes new data when it is empty or its content moves on.
  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_comb begin
    a_valid_d   = a_ready ? valid_i : a_valid_q;
    a_pclk_hz_d = PclkHzW'(pclk_i) * PclkHzW'(PclkScale);
    a_n_d       = pick_n(rate_i);
  end

  always_comb begin
    b_valid_d = b_ready ? a_valid_q : b_valid_q;
    b_num_d   = NumW'(a_pclk_hz_q) * NumW'(a_n_q[NW-1:NShift]);
    b_err_d   = (a_rate_q == '0);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // Payload registers load only on a transaction into the stage.
  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      a_pclk_hz_q <= a_pclk_hz_d;
      a_rate_q    <= rate_i;
      a_n_q       <= a_n_d;
    end
    if (a_valid_q && b_ready) begin
      b_num_q  <= b_num_d;
      b_rate_q <= a_rate_q;
      b_n_q    <= a_n_q;
      b_err_q  <= b_err_d;
    end
  end

  // Seed the divider: empty remainder, numerator in the shift register.
  always_comb begin
    stage_o.rem     = '0;
    stage_o.dq      = b_num_q;
    stage_o.divisor = b_rate_q;
    stage_o.n       = b_n_q;
    stage_o.err     = b_err_q;
  end
  assign valid_o = b_valid_q;

  `HACR_ASSERT_IMPL(a_n_in_table, a_valid_q,
    a_n_q == N32k || a_n_q == N44k1 || a_n_q == N48k || a_n_q == N88k2 ||
    a_n_q == N96k || a_n_q == N176k4 || a_n_q == N192k, "N outside the standard table")
  `HACR_ASSERT_IMPL(a_err_fallback, b_valid_q && b_err_q, b_n_q == NFallback,
    "zero rate did not take the fallback N")

endmodule

### sv/hacr_div_stage.sv
`include "hdmi_acr_n_cts_calc_assert.svh"

module hacr_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  hacr_pkg::div_t stage_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hacr_pkg::div_t stage_o
);
  import hacr_pkg::*;

  logic             valid_d, valid_q;
  div_t             data_d, data_q;
  logic [RemW-1:0]  rem_v;
  logic [NumW-1:0]  dq_v;
  logic [RemW:0]    trial;
  logic [RemW:0]    div_ext;

  assign ready_o = !valid_q || ready_i;

  // Restoring division, a few quotient bits per stage.
  always_comb begin
    rem_v   = stage_i.rem;
    dq_v    = stage_i.dq;
    div_ext = {1'b0, stage_i.divisor};
    trial   = '0;
    for (int k = 0; k < DivBitsPerStage; k++) begin
      trial = {rem_v, dq_v[NumW-1]};
      if (trial >= div_ext) begin
        rem_v = RemW'(trial - div_ext);
        dq_v  = {dq_v[NumW-2:0], 1'b1};
      end else begin
        rem_v = trial[RemW-1:0];
        dq_v  = {dq_v[NumW-2:0], 1'b0};
      end
    end
    data_d         = stage_i;
    data_d.rem     = rem_v;
    data_d.dq      = dq_v;
    valid_d        = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = data_q;

  `HACR_ASSERT_IMPL(a_rem_below_div, valid_q && data_q.divisor != '0,
    data_q.rem < data_q.divisor, "partial remainder not below the divisor")
  `HACR_ASSERT(a_stall_holds, valid_q && !ready_i |=> valid_q && $stable(data_q),
    "stalled divider stage lost its content")

endmodule

### sv/hdmi_acr_n_cts_calc.sv
// Channel   | Dir | tdata (low bit up)                          | tuser (low bit up)
// s_axis    | in  | pixel_clock_khz[21:0], audio_rate_hz[39:22] | -
// m_axis    | out | n_value[14:0], cts_value[46:15], zero pad   | cts_overflow, rate_error
//
// One transaction is accepted per cycle while m_axis is not stalled; each passes through
// registered stages for the N lookup and the numerator multiplies, then ten divider stages of four
// quotient bits each. The preparation and divider stages set the latency.
// Reset clears only the valid bits; payload registers are loaded on a transaction.
// A stall on m_axis fills empty stages first, then holds every stage in place.
`include "hdmi_acr_n_cts_calc_assert.svh"

module hdmi_acr_n_cts_calc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hacr_pkg::InTdataW-1:0]    s_axis_tdata,   // pixel_clock_khz, audio_rate_hz
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hacr_pkg::OutTdataW-1:0]   m_axis_tdata,   // n_value, cts_value, zeros
  output logic [hacr_pkg::OutTuserW-1:0]   m_axis_tuser    // cts_overflow, rate_error
);
  import hacr_pkg::*;

  div_t  stage   [DivStages+1];
  logic  valid   [DivStages+1];
  logic  ready   [DivStages+1];
  div_t  last;
  logic  ovf;
  logic  [CtsW-1:0] cts;

  // Operand preparation.
  hacr_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pclk_i  (s_axis_tdata[PclkW-1:0]),
    .rate_i  (s_axis_tdata[PclkW+RateW-1:PclkW]),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .stage_o (stage[0])
  );

  // Divider pipeline.
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    hacr_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .stage_i (stage[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .stage_o (stage[g+1])
    );
  end

  assign ready[DivStages] = m_axis_tready;

  // Result fields; a zero rate forces CTS and overflow to zero.
  always_comb begin
    last = stage[DivStages];
    cts  = last.err ? '0 : last.dq[CtsW-1:0];
    ovf  = !last.err && (last.dq[NumW-1:CtsW] != '0);
  end

  assign m_axis_tvalid = valid[DivStages];
  assign m_axis_tdata  = {(OutTdataW-NW-CtsW)'(0), cts, last.n};
  assign m_axis_tuser  = {last.err, ovf};

  `HACR_ASSERT_IMPL(a_ready_passes, m_axis_tready, s_axis_tready,
    "input stalled while the output side is ready")
  `HACR_ASSERT_IMPL(a_err_clean, m_axis_tvalid && m_axis_tuser[1],
    m_axis_tdata[NW-1:0] == NFallback && !m_axis_tuser[0],
    "zero-rate result carries wrong N or an overflow")

endmodule
